// ----- hdl/page_framebuffer_draw_engine_assert.svh -----
// Assertion macros used by the draw engine top level.
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFDE_ASSERT_NOW(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PFDE_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error(msg);

`endif

// ----- hdl/pfde_pkg.sv -----
// Package with the types, constants and helper functions of the page framebuffer draw engine.
`default_nettype none

package pfde_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int STORE_DEPTH   = 1024;

  localparam int DEPTH_W   = $clog2(STORE_DEPTH);
  localparam int NUM_PAGES = (SCREEN_HEIGHT + 7) / 8;
  localparam int PAGE_W    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int COL_W     = $clog2(SCREEN_WIDTH + 1);
  localparam int ADDR_W    = $clog2(NUM_PAGES * SCREEN_WIDTH) + 1;

  localparam logic [7:0] TOP_BITS [8] =
    '{8'h00, 8'h80, 8'hC0, 8'hE0, 8'hF0, 8'hF8, 8'hFC, 8'hFE};
  localparam logic [7:0] BOTTOM_BITS [8] =
    '{8'h00, 8'h01, 8'h03, 8'h07, 8'h0F, 8'h1F, 8'h3F, 8'h7F};

  typedef enum logic [2:0] {
    OP_PIXEL = 3'd0,
    OP_HLINE = 3'd1,
    OP_VLINE = 3'd2,
    OP_RECT  = 3'd3,
    OP_CLEAR = 3'd4,
    OP_READ  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    PEN_WHITE  = 2'd0,
    PEN_BLACK  = 2'd1,
    PEN_INVERT = 2'd2
  } pen_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_FLUSH,
    ST_READ,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] w;
    logic [7:0] h;
    pen_e       pen;
    logic [9:0] idx;
  } cmd_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] read_data;
    logic       ignored;
  } res_t;

  typedef struct packed {
    logic               re;
    logic [DEPTH_W-1:0] raddr;
    logic               we;
    logic [DEPTH_W-1:0] waddr;
    logic [7:0]         wdata;
  } ram_req_t;

  // Bits lo up to hi of one byte set.
  function automatic logic [7:0] byte_mask(input logic [2:0] lo, input logic [2:0] hi);
    byte_mask = ~BOTTOM_BITS[lo] & ~TOP_BITS[3'd7 - hi];
  endfunction

  function automatic logic [7:0] apply_pen(input logic [7:0] data, input logic [7:0] mask,
                                           input pen_e pen);
    case (pen)
      PEN_WHITE:  apply_pen = data | mask;
      PEN_BLACK:  apply_pen = data & ~mask;
      PEN_INVERT: apply_pen = data ^ mask;
      default:    apply_pen = data;
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- hdl/pfde_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module pfde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pfde_ctrl.sv -----
// Sequencer that walks spans byte by byte, reads, modifies and writes back the frame store.
`default_nettype none

module pfde_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_ready_o,
  input  wire pfde_pkg::op_e     cmd_op_i,
  input  wire pfde_pkg::cmd_t    cmd_i,
  input  wire logic              res_free_i,
  output pfde_pkg::res_t         res_o,
  output pfde_pkg::ram_req_t     ram_req_o,
  input  wire logic [7:0]        ram_rdata_i
);

  pfde_pkg::state_e state_q, state_d;

  logic [pfde_pkg::COL_W-1:0]   col_q, col_d, col_end_q, col_end_d;
  logic [pfde_pkg::PAGE_W-1:0]  page_q, page_d, page_first_q, page_first_d;
  logic [pfde_pkg::PAGE_W-1:0]  page_last_q, page_last_d;
  logic [2:0]                   row_lo_q, row_lo_d, row_hi_q, row_hi_d;
  pfde_pkg::pen_e               pen_q, pen_d;
  logic                         wr_pend_q, wr_pend_d;
  logic [pfde_pkg::DEPTH_W-1:0] wr_addr_q, wr_addr_d;
  logic [7:0]                   wr_mask_q, wr_mask_d;
  logic [pfde_pkg::DEPTH_W-1:0] clr_addr_q, clr_addr_d;
  logic                         clr_reply_q, clr_reply_d;
  logic [7:0]                   res_data_q, res_data_d;
  logic                         res_ign_q, res_ign_d;

  logic       is_draw, off_screen, empty_span, one_col, one_row;
  logic [7:0] span_w, span_h;
  logic [8:0] col_sum, col_clip, row_sum, row_clip, row_last;
  logic [pfde_pkg::ADDR_W-1:0] walk_addr;
  logic       in_store, last_page, last_col, clr_done;
  logic [2:0] lo_sel, hi_sel;

  always_comb begin
    is_draw    = cmd_op_i inside {pfde_pkg::OP_PIXEL, pfde_pkg::OP_HLINE,
                                  pfde_pkg::OP_VLINE, pfde_pkg::OP_RECT};
    off_screen = ({1'b0, cmd_i.x} >= 9'(pfde_pkg::SCREEN_WIDTH)) ||
                 ({1'b0, cmd_i.y} >= 9'(pfde_pkg::SCREEN_HEIGHT));
    one_col    = cmd_op_i inside {pfde_pkg::OP_PIXEL, pfde_pkg::OP_VLINE};
    one_row    = cmd_op_i inside {pfde_pkg::OP_PIXEL, pfde_pkg::OP_HLINE};
    span_w     = one_col ? 8'd1 : cmd_i.w;
    span_h     = one_row ? 8'd1 : cmd_i.h;
    empty_span = (span_w == 8'd0) || (span_h == 8'd0);
    col_sum    = {1'b0, cmd_i.x} + {1'b0, span_w};
    col_clip   = (col_sum > 9'(pfde_pkg::SCREEN_WIDTH)) ? 9'(pfde_pkg::SCREEN_WIDTH) : col_sum;
    row_sum    = {1'b0, cmd_i.y} + {1'b0, span_h};
    row_clip   = (row_sum > 9'(pfde_pkg::SCREEN_HEIGHT)) ? 9'(pfde_pkg::SCREEN_HEIGHT) : row_sum;
    row_last   = row_clip - 9'd1;

    walk_addr  = pfde_pkg::ADDR_W'(page_q) * pfde_pkg::ADDR_W'(pfde_pkg::SCREEN_WIDTH) +
                 pfde_pkg::ADDR_W'(col_q);
    in_store   = 32'(walk_addr) < 32'(pfde_pkg::STORE_DEPTH);
    last_page  = page_q == page_last_q;
    last_col   = pfde_pkg::COL_W'(col_q + pfde_pkg::COL_W'(1)) == col_end_q;
    lo_sel     = (page_q == page_first_q) ? row_lo_q : 3'd0;
    hi_sel     = last_page ? row_hi_q : 3'd7;
    clr_done   = clr_addr_q == pfde_pkg::DEPTH_W'(pfde_pkg::STORE_DEPTH - 1);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pfde_pkg::ST_CLEAR: begin
        if (clr_done) begin
          state_d = clr_reply_q ? pfde_pkg::ST_RESP : pfde_pkg::ST_IDLE;
        end
      end
      pfde_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          if (is_draw) begin
            state_d = (off_screen || empty_span) ? pfde_pkg::ST_RESP : pfde_pkg::ST_WALK;
          end else if (cmd_op_i == pfde_pkg::OP_CLEAR) begin
            state_d = pfde_pkg::ST_CLEAR;
          end else if (cmd_op_i == pfde_pkg::OP_READ) begin
            state_d = pfde_pkg::ST_READ;
          end else begin
            state_d = pfde_pkg::ST_RESP;
          end
        end
      end
      pfde_pkg::ST_WALK: begin
        if (last_page && last_col) begin
          state_d = pfde_pkg::ST_FLUSH;
        end
      end
      pfde_pkg::ST_FLUSH: state_d = pfde_pkg::ST_RESP;
      pfde_pkg::ST_READ:  state_d = pfde_pkg::ST_RESP;
      pfde_pkg::ST_RESP: begin
        if (res_free_i) begin
          state_d = pfde_pkg::ST_IDLE;
        end
      end
      default: state_d = pfde_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready_o     = state_q == pfde_pkg::ST_IDLE;
    res_o.valid     = state_q == pfde_pkg::ST_RESP;
    res_o.read_data = res_data_q;
    res_o.ignored   = res_ign_q;

    ram_req_o.re    = 1'b0;
    ram_req_o.raddr = pfde_pkg::DEPTH_W'(walk_addr);
    ram_req_o.we    = wr_pend_q;
    ram_req_o.waddr = wr_addr_q;
    ram_req_o.wdata = pfde_pkg::apply_pen(ram_rdata_i, wr_mask_q, pen_q);
    case (state_q)
      pfde_pkg::ST_CLEAR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = clr_addr_q;
        ram_req_o.wdata = 8'h00;
      end
      pfde_pkg::ST_IDLE: begin
        ram_req_o.re    = cmd_valid_i && (cmd_op_i == pfde_pkg::OP_READ);
        ram_req_o.raddr = pfde_pkg::DEPTH_W'(cmd_i.idx);
      end
      pfde_pkg::ST_WALK: ram_req_o.re = 1'b1;
      default: ram_req_o.re = 1'b0;
    endcase
  end

  always_comb begin
    col_d        = col_q;
    col_end_d    = col_end_q;
    page_d       = page_q;
    page_first_d = page_first_q;
    page_last_d  = page_last_q;
    row_lo_d     = row_lo_q;
    row_hi_d     = row_hi_q;
    pen_d        = pen_q;
    wr_pend_d    = 1'b0;
    wr_addr_d    = pfde_pkg::DEPTH_W'(walk_addr);
    wr_mask_d    = pfde_pkg::byte_mask(lo_sel, hi_sel);
    clr_addr_d   = clr_addr_q;
    clr_reply_d  = clr_reply_q;
    res_data_d   = res_data_q;
    res_ign_d    = res_ign_q;
    case (state_q)
      pfde_pkg::ST_CLEAR: clr_addr_d = pfde_pkg::DEPTH_W'(clr_addr_q + 1'b1);
      pfde_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          col_d        = pfde_pkg::COL_W'(cmd_i.x);
          col_end_d    = pfde_pkg::COL_W'(col_clip);
          page_d       = pfde_pkg::PAGE_W'(cmd_i.y >> 3);
          page_first_d = pfde_pkg::PAGE_W'(cmd_i.y >> 3);
          page_last_d  = pfde_pkg::PAGE_W'(row_last >> 3);
          row_lo_d     = cmd_i.y[2:0];
          row_hi_d     = row_last[2:0];
          pen_d        = cmd_i.pen;
          clr_addr_d   = '0;
          clr_reply_d  = 1'b1;
          res_data_d   = 8'h00;
          res_ign_d    = is_draw && off_screen;
        end
      end
      pfde_pkg::ST_WALK: begin
        wr_pend_d = in_store;
        if (last_page) begin
          page_d = page_first_q;
          col_d  = pfde_pkg::COL_W'(col_q + pfde_pkg::COL_W'(1));
        end else begin
          page_d = pfde_pkg::PAGE_W'(page_q + pfde_pkg::PAGE_W'(1));
        end
      end
      pfde_pkg::ST_READ: res_data_d = ram_rdata_i;
      default: res_data_d = res_data_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfde_pkg::ST_CLEAR;
      clr_addr_q  <= '0;
      clr_reply_q <= 1'b0;
      wr_pend_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      clr_reply_q <= clr_reply_d;
      wr_pend_q   <= wr_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q        <= col_d;
    col_end_q    <= col_end_d;
    page_q       <= page_d;
    page_first_q <= page_first_d;
    page_last_q  <= page_last_d;
    row_lo_q     <= row_lo_d;
    row_hi_q     <= row_hi_d;
    pen_q        <= pen_d;
    wr_addr_q    <= wr_addr_d;
    wr_mask_q    <= wr_mask_d;
    res_data_q   <= res_data_d;
    res_ign_q    <= res_ign_d;
  end

endmodule

`default_nettype wire

// ----- hdl/page_framebuffer_draw_engine.sv -----
// Top level of the page framebuffer draw engine: store, sequencer and result register.
//
//   Channel   Direction  Payload
//   s_axis    in         tuser: operation; tdata: x, y, width, height, pen, byte index
//   m_axis    out        tdata: read data, ignored flag
//
// A draw request visits each store byte touched (columns times pages) once,
// in the single read-modify-write walk over the frame store.
// An empty or off-screen draw and an unused operation skip the walk; a read fetches one byte.
// A clear sweeps the store and zeroes every byte of it.
// After reset a pass zeroes every store byte; no request is taken during it.
// A finished result waits in the output register; the next request is taken meanwhile.
`default_nettype none

`include "page_framebuffer_draw_engine_assert.svh"

module page_framebuffer_draw_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] x_pos, [15:8] y_pos, [23:16] span_width, [31:24] span_height,
  // [33:32] pen, [43:34] byte_index, [47:44] zero
  input  wire logic [47:0] s_axis_tdata,
  // [2:0] operation
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] read_data, [8] ignored, [15:9] zero
  output logic [15:0]      m_axis_tdata
);

  pfde_pkg::cmd_t     cmd;
  pfde_pkg::res_t     res;
  pfde_pkg::ram_req_t ram_req;
  logic [7:0]         ram_rdata;
  logic               res_free, res_load;
  logic               m_valid_q, m_valid_d;
  logic [7:0]         m_data_q, m_data_d;
  logic               m_ign_q, m_ign_d;

  always_comb begin
    cmd.x   = s_axis_tdata[7:0];
    cmd.y   = s_axis_tdata[15:8];
    cmd.w   = s_axis_tdata[23:16];
    cmd.h   = s_axis_tdata[31:24];
    cmd.pen = pfde_pkg::pen_e'(s_axis_tdata[33:32]);
    cmd.idx = s_axis_tdata[43:34];
  end

  pfde_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .cmd_op_i    (pfde_pkg::op_e'(s_axis_tuser)),
    .cmd_i       (cmd),
    .res_free_i  (res_free),
    .res_o       (res),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  pfde_ram #(
    .WIDTH (8),
    .DEPTH (pfde_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    res_free  = !m_valid_q || m_axis_tready;
    res_load  = res.valid && res_free;
    m_valid_d = res_load || (m_valid_q && !m_axis_tready);
    m_data_d  = res_load ? res.read_data : m_data_q;
    m_ign_d   = res_load ? res.ignored : m_ign_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_ign_q  <= m_ign_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, m_ign_q, m_data_q};

  `PFDE_ASSERT_NOW(a_idle_no_store_write, s_axis_tready, !ram_req.we, "store written while idle")
  `PFDE_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready, "not busy")
  `PFDE_ASSERT_NOW(a_result_needs_room, m_valid_q && !m_axis_tready, !res_load, "result overrun")

endmodule

`default_nettype wire
